[design/ffra_pkg.sv]
package ffra_pkg;

  localparam int MAX_BLOCKS_DEF       = 64;
  localparam int REGION_ADDR_BITS_DEF = 20;

  localparam int ADDR_W   = 32;
  localparam int SIZE_W   = 21;
  localparam int STATUS_W = 3;
  localparam int USE_W    = 7;
  localparam int OP_W     = 2;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [ADDR_W-1:0] BASE_RESET   = '0;
  localparam logic [SIZE_W-1:0] REGION_RESET = SIZE_W'(1048576);

  // Sizes must be multiples of eight bytes.
  localparam int ALIGN_BITS = 3;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND  = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_SPACE  = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_SIZE  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd4;

  // Register select is address bit 2.
  localparam logic REG_BASE   = 1'b0;
  localparam logic REG_REGION = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] target_address;
  } ffra_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   block_address;
    logic [SIZE_W-1:0]   block_size;
    logic [USE_W-1:0]    blocks_in_use;
  } ffra_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_TAIL,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_LOOK_RD,
    S_LOOK_CHK,
    S_DEL_RD,
    S_DEL_WR,
    S_DONE
  } ffra_state_t;

endpackage

[design/first_fit_region_allocator.sv]
// Channel   | Ports                                    | Handshake
// ----------+------------------------------------------+---------------------------------
// request   | start, busy, in_req                      | taken when start & !busy
// result    | out_valid, out_res                       | one-cycle strobe, no back-pressure
// config    | psel, penable, pwrite, paddr, pwdata,    | APB write on psel & penable &
//           | prdata, pready                           | pwrite; pready tied high
//
// One sequencer and one table memory: a request goes through dispatch, then a scan or lookup
// that reads one entry at a time and any entry moves, then the done state; an allocate tries
// the gaps before the region end and writes its new entry last, and clear resets the count.
// busy stays high until the result strobe has been shown, and the receiver cannot stall it.
// Synchronous active-low reset empties the table and restores the register reset values;
// table contents are not cleared.
module first_fit_region_allocator
  import ffra_pkg::*;
#(
  parameter int MAX_BLOCKS       = MAX_BLOCKS_DEF,
  parameter int REGION_ADDR_BITS = REGION_ADDR_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ffra_in_t           in_req,
  output logic               out_valid,
  output ffra_out_t          out_res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int RAB = REGION_ADDR_BITS;
  localparam int AW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW  = $clog2(MAX_BLOCKS + 1);
  localparam int PW  = RAB + 1;
  localparam int EW  = ((PW > SIZE_W) ? PW : SIZE_W) + 1;
  localparam int DW  = RAB + SIZE_W;
  localparam logic [EW-1:0] REGION_LIM = EW'(1) << RAB;
  localparam logic [CW-1:0] MAX_CNT    = CW'(MAX_BLOCKS);

  ffra_state_t state_r, state_nxt;

  logic [OP_W-1:0]     op_r, op_nxt;
  logic [SIZE_W-1:0]   size_r, size_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [ADDR_W-1:0]   off_r, off_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       pos_r, pos_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [PW-1:0]       prev_end_r, prev_end_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]   res_addr_r, res_addr_nxt;
  logic [SIZE_W-1:0]   res_size_r, res_size_nxt;
  logic [ADDR_W-1:0]   base_r;
  logic [SIZE_W-1:0]   region_r;

  logic [DW-1:0] mem [MAX_BLOCKS];
  logic [DW-1:0] rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [AW-1:0] mem_ra;
  logic [DW-1:0] mem_wd;

  logic              accept;
  logic [RAB-1:0]    ent_start;
  logic [SIZE_W-1:0] ent_size;
  logic [EW-1:0]     usable;
  logic              bad_size;
  logic              gap_fit;
  logic              end_fit;
  logic              match;
  logic [CW-1:0]     pos_inc;
  logic [CW-1:0]     idx_inc;
  logic [CW-1:0]     idx_dec;
  logic              cfg_wr;

  assign accept    = start && (state_r == S_IDLE);
  assign ent_start = rd_data_r[SIZE_W +: RAB];
  assign ent_size  = rd_data_r[SIZE_W-1:0];
  assign usable    = (EW'(region_r) > REGION_LIM) ? REGION_LIM : EW'(region_r);
  assign bad_size  = (size_r == '0) || (size_r[ALIGN_BITS-1:0] != '0);
  assign gap_fit   = (EW'(ent_start) >= EW'(prev_end_r)) &&
                     ((EW'(ent_start) - EW'(prev_end_r)) >= EW'(size_r));
  assign end_fit   = (EW'(prev_end_r) + EW'(size_r)) <= usable;
  assign match     = (ADDR_W'(ent_start) == off_r);
  assign pos_inc   = pos_r + CW'(1);
  assign idx_inc   = idx_r + CW'(1);
  assign idx_dec   = idx_r - CW'(1);

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_REGION) ? PDATA_W'(region_r) : base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= BASE_RESET;
      region_r <= REGION_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_BASE) begin
        base_r <= pwdata;
      end else begin
        region_r <= pwdata[SIZE_W-1:0];
      end
    end
  end

  // Table memory: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (op_r)
          OP_ALLOC: begin
            if (bad_size || (count_r >= MAX_CNT)) state_nxt = S_DONE;
            else if (count_r == '0) state_nxt = S_TAIL;
            else state_nxt = S_SCAN_RD;
          end
          OP_FREE, OP_FIND: begin
            state_nxt = (count_r == '0) ? S_DONE : S_LOOK_RD;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_SCAN_RD: state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (gap_fit) state_nxt = S_INS_RD;
        else if (pos_inc == count_r) state_nxt = S_TAIL;
        else state_nxt = S_SCAN_RD;
      end
      S_TAIL: state_nxt = end_fit ? S_INS_PUT : S_DONE;
      S_INS_RD: state_nxt = S_INS_WR;
      S_INS_WR: state_nxt = (idx_dec == pos_r) ? S_INS_PUT : S_INS_RD;
      S_INS_PUT: state_nxt = S_DONE;
      S_LOOK_RD: state_nxt = S_LOOK_CHK;
      S_LOOK_CHK: begin
        if (match) begin
          if (op_r == OP_FREE && pos_inc != count_r) state_nxt = S_DEL_RD;
          else state_nxt = S_DONE;
        end else if (pos_inc == count_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_LOOK_RD;
        end
      end
      S_DEL_RD: state_nxt = S_DEL_WR;
      S_DEL_WR: state_nxt = (idx_inc == count_r) ? S_DONE : S_DEL_RD;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    op_nxt         = op_r;
    size_nxt       = size_r;
    addr_nxt       = addr_r;
    off_nxt        = off_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    idx_nxt        = idx_r;
    prev_end_nxt   = prev_end_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    res_size_nxt   = res_size_r;
    mem_we         = 1'b0;
    mem_wa         = idx_r[AW-1:0];
    mem_wd         = rd_data_r;
    mem_ra         = pos_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt   = in_req.opcode;
          size_nxt = in_req.request_size;
          addr_nxt = in_req.target_address;
          off_nxt  = in_req.target_address - base_r;
        end
      end
      S_DISPATCH: begin
        res_status_nxt = STAT_OK;
        res_addr_nxt   = '0;
        res_size_nxt   = '0;
        pos_nxt        = '0;
        idx_nxt        = '0;
        prev_end_nxt   = '0;
        unique case (op_r)
          OP_ALLOC: begin
            if (bad_size) res_status_nxt = STAT_BAD_SIZE;
            else if (count_r >= MAX_CNT) res_status_nxt = STAT_FULL;
          end
          OP_FREE, OP_FIND: begin
            if (count_r == '0) res_status_nxt = STAT_NOT_FOUND;
          end
          default: count_nxt = '0;
        endcase
      end
      S_SCAN_CHK: begin
        if (gap_fit) begin
          idx_nxt = count_r;
        end else begin
          prev_end_nxt = PW'(EW'(ent_start) + EW'(ent_size));
          pos_nxt      = pos_inc;
        end
      end
      S_TAIL: begin
        if (end_fit) begin
          pos_nxt = count_r;
          idx_nxt = count_r;
        end else begin
          res_status_nxt = STAT_NO_SPACE;
        end
      end
      S_INS_RD: begin
        mem_ra = idx_dec[AW-1:0];
      end
      S_INS_WR: begin
        mem_we  = 1'b1;
        idx_nxt = idx_dec;
      end
      S_INS_PUT: begin
        mem_we         = 1'b1;
        mem_wa         = pos_r[AW-1:0];
        mem_wd         = {prev_end_r[RAB-1:0], size_r};
        count_nxt      = count_r + CW'(1);
        res_addr_nxt   = base_r + ADDR_W'(prev_end_r);
        res_size_nxt   = size_r;
      end
      S_LOOK_CHK: begin
        if (match) begin
          res_addr_nxt = addr_r;
          res_size_nxt = ent_size;
          idx_nxt      = pos_r;
          if (op_r == OP_FREE) count_nxt = count_r - CW'(1);
        end else begin
          pos_nxt = pos_inc;
          if (pos_inc == count_r) res_status_nxt = STAT_NOT_FOUND;
        end
      end
      S_DEL_RD: begin
        mem_ra = idx_inc[AW-1:0];
      end
      S_DEL_WR: begin
        mem_we  = 1'b1;
        idx_nxt = idx_inc;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    size_r       <= size_nxt;
    addr_r       <= addr_nxt;
    off_r        <= off_nxt;
    pos_r        <= pos_nxt;
    idx_r        <= idx_nxt;
    prev_end_r   <= prev_end_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_size_r   <= res_size_nxt;
  end

  assign busy                  = (state_r != S_IDLE);
  assign out_valid             = (state_r == S_DONE);
  assign out_res.status        = res_status_r;
  assign out_res.block_address = res_addr_r;
  assign out_res.block_size    = res_size_r;
  assign out_res.blocks_in_use = USE_W'(count_r);

endmodule
